// ===== sv/chacha_pkg.sv =====
// chacha20 keystream package: state types, register indexes and round functions
package chacha_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] state_type;
   typedef logic [3:0][63:0] key_type;
   typedef logic [7:0][63:0] block_type;

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_WORD0  = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD1  = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD2  = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD3  = 3'd3;
   localparam logic [2:0] CSR_NONCE_LOW  = 3'd4;
   localparam logic [2:0] CSR_NONCE_HIGH = 3'd5;

   localparam logic [2:0] LAST_WORD_INDEX = 3'd7;

   // sigma constants "expand 32-byte k"
   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646e;
   localparam word_type SIGMA2 = 32'h79622d32;
   localparam word_type SIGMA3 = 32'h6b206574;

   // starting state from the key, nonce and block counter
   function automatic state_type init_state(input word_type ctr, input key_type key,
                                            input logic [63:0] nonce_low,
                                            input word_type nonce_high);
      state_type s;
      s[0]  = SIGMA0;
      s[1]  = SIGMA1;
      s[2]  = SIGMA2;
      s[3]  = SIGMA3;
      s[4]  = key[0][31:0];
      s[5]  = key[0][63:32];
      s[6]  = key[1][31:0];
      s[7]  = key[1][63:32];
      s[8]  = key[2][31:0];
      s[9]  = key[2][63:32];
      s[10] = key[3][31:0];
      s[11] = key[3][63:32];
      s[12] = ctr;
      s[13] = nonce_low[31:0];
      s[14] = nonce_low[63:32];
      s[15] = nonce_high;
      return s;
   endfunction

   // one half of a column or diagonal round: first half rotates by 16 and 12,
   // second half by 8 and 7; the four quarter rounds are independent
   function automatic state_type half_round(input state_type x, input logic diag,
                                            input logic second);
      state_type y;
      logic [1:0] ob;
      logic [1:0] oc;
      logic [1:0] od;
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type t;
      y = x;
      for (int q = 0; q < 4; q++) begin
         ob = 2'(q) + {1'b0, diag};
         oc = 2'(q) + {diag, 1'b0};
         od = 2'(q) + {diag, diag};
         a = x[q];
         b = x[{2'b01, ob}];
         c = x[{2'b10, oc}];
         d = x[{2'b11, od}];
         a = a + b;
         t = d ^ a;
         if (second) begin
            d = {t[23:0], t[31:24]};
         end else begin
            d = {t[15:0], t[31:16]};
         end
         c = c + d;
         t = b ^ c;
         if (second) begin
            b = {t[24:0], t[31:25]};
         end else begin
            b = {t[19:0], t[31:20]};
         end
         y[q]             = a;
         y[{2'b01, ob}]   = b;
         y[{2'b10, oc}]   = c;
         y[{2'b11, od}]   = d;
      end
      return y;
   endfunction

endpackage

// ===== sv/chacha20_keystream_block.sv =====
// chacha20 keystream block: half-round pipeline and 64-bit output serializer
//
// Usage: load the key (indexes 0..3), nonce_low (4) and nonce_high (5)
// through the csr port while the block is idle. Each request transfer
// carries a 32-bit block counter; the block answers with eight response
// transfers of 64 bits each, word_index 0..7, last_word set on index 7.
// Word k holds output state word 2k in the low half and 2k+1 in the high.
// The rounds run in a pipeline of 4*DOUBLE_ROUNDS stages, one half of a
// column or diagonal round per stage, so a new request can enter every
// cycle while req_stall is low. The single 64-bit response port limits
// the sustained rate: the serializer loads a new block only as the last
// word of the current one is transferred. When rsp_stall is held the
// serializer and then the pipeline fill up and req_stall rises; nothing
// is dropped or repeated. A synchronous reset clears all valid bits and
// sets the key and nonce registers to zero.
module chacha20_keystream_block #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_block_counter,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_keystream_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import chacha_pkg::*;

   localparam int NSTAGE = 4 * DOUBLE_ROUNDS;

   // configuration registers
   key_type     key_ff;
   logic [63:0] nonce_low_ff;
   word_type    nonce_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_WORD0:  key_ff[0]     <= csr_wdata;
            CSR_KEY_WORD1:  key_ff[1]     <= csr_wdata;
            CSR_KEY_WORD2:  key_ff[2]     <= csr_wdata;
            CSR_KEY_WORD3:  key_ff[3]     <= csr_wdata;
            CSR_NONCE_LOW:  nonce_low_ff  <= csr_wdata;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // round pipeline
   logic [NSTAGE:0]   stage_open;
   logic [NSTAGE-1:0] vld_ff;
   state_type         st_ff  [NSTAGE];
   word_type          ctr_ff [NSTAGE];
   logic              ser_open;

   assign stage_open[NSTAGE] = ser_open;
   assign req_stall          = !stage_open[0];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam logic DIAG   = 1'((s / 2) % 2);
      localparam logic SECOND = 1'(s % 2);
      state_type src;
      logic      src_vld;
      word_type  src_ctr;
      state_type st_in;

      if (s == 0) begin : g_first
         assign src     = init_state(req_block_counter, key_ff, nonce_low_ff, nonce_high_ff);
         assign src_vld = req_valid;
         assign src_ctr = req_block_counter;
      end else begin : g_next
         assign src     = st_ff[s-1];
         assign src_vld = vld_ff[s-1];
         assign src_ctr = ctr_ff[s-1];
      end

      assign st_in         = half_round(src, DIAG, SECOND);
      assign stage_open[s] = !vld_ff[s] || stage_open[s+1];

      // valid bit moves whenever the stage is open
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (stage_open[s]) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_open[s]) begin
            st_ff[s]  <= st_in;
            ctr_ff[s] <= src_ctr;
         end
      end
   end

   // feed-forward add of the starting state
   state_type init_last;
   state_type sum_state;

   assign init_last = init_state(ctr_ff[NSTAGE-1], key_ff, nonce_low_ff, nonce_high_ff);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sum_state[i] = st_ff[NSTAGE-1][i] + init_last[i];
      end
   end

   // output serializer
   block_type  ser_word_ff;
   block_type  ser_word_in;
   logic       ser_vld_ff;
   logic       ser_vld_in;
   logic [2:0] ser_idx_ff;
   logic [2:0] ser_idx_in;
   logic       ser_load;
   logic       rsp_xfer;

   assign rsp_xfer    = ser_vld_ff && !rsp_stall;
   assign ser_open    = !ser_vld_ff || (rsp_xfer && (ser_idx_ff == LAST_WORD_INDEX));
   assign ser_load    = vld_ff[NSTAGE-1] && ser_open;
   assign ser_word_in = sum_state;

   always_comb begin
      ser_vld_in = ser_vld_ff;
      ser_idx_in = ser_idx_ff;
      if (ser_load) begin
         ser_vld_in = 1'b1;
         ser_idx_in = '0;
      end else if (rsp_xfer) begin
         if (ser_idx_ff == LAST_WORD_INDEX) begin
            ser_vld_in = 1'b0;
         end
         ser_idx_in = ser_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_idx_ff <= '0;
      end else begin
         ser_vld_ff <= ser_vld_in;
         ser_idx_ff <= ser_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_word_ff <= ser_word_in;
      end
   end

   assign rsp_valid          = ser_vld_ff;
   assign rsp_keystream_word = ser_word_ff[ser_idx_ff];
   assign rsp_word_index     = ser_idx_ff;
   assign rsp_last_word      = (ser_idx_ff == LAST_WORD_INDEX);

`ifndef SYNTH
   // a word transfer short of the last is followed by the next word
   a_word_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && (rsp_word_index != LAST_WORD_INDEX)) |=>
      (rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1)))
      else $error("response word index did not advance");

   // a newly loaded block starts at word zero
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (rsp_valid && (rsp_word_index == 3'd0)))
      else $error("loaded block does not start at word zero");

   // the request side only stalls when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("request stalled with an empty pipeline stage");
`endif

endmodule

// ===== sim/tb_top.sv =====
// testbench for chacha20_keystream_block: checks every keystream word against a local predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import chacha_pkg::*;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 4 * DOUBLE_ROUNDS + 16;
   localparam int RANDOM_BLOCKS = 64;

   // indexes past the last register, writes there must be ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } keystream_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_block_counter;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_keystream_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // predictor copy of the key and nonce registers
   key_type     key_reg;
   logic [63:0] nonce_low_reg;
   word_type    nonce_high_reg;

   word_type           counter_queue[$];
   keystream_beat_type keystream_expected[$];

   logic req_taken;
   int   send_idle_pct;
   int   stall_pct;
   int   blocks_queued;
   int   blocks_accepted;
   int   words_checked;
   int   settings_loaded;
   int   error_count;
   int   quiet_cycles;

   chacha20_keystream_block #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_block_counter(req_block_counter),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_keystream_word(rsp_keystream_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always #2 clock = ~clock;

   // chacha arithmetic
   function automatic word_type rotl(input word_type v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void quarter_round(inout word_type a, inout word_type b,
                                         inout word_type c, inout word_type d);
      a = a + b; d = d ^ a; d = rotl(d, 16);
      c = c + d; b = b ^ c; b = rotl(b, 12);
      a = a + b; d = d ^ a; d = rotl(d, 8);
      c = c + d; b = b ^ c; b = rotl(b, 7);
   endfunction

   // full 64-byte keystream block for one counter under the current settings
   function automatic block_type chacha_keystream(input word_type ctr);
      word_type  start[16];
      word_type  x[16];
      block_type ks;
      start[0] = SIGMA0;
      start[1] = SIGMA1;
      start[2] = SIGMA2;
      start[3] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
         start[4 + 2 * i] = key_reg[i][31:0];
         start[5 + 2 * i] = key_reg[i][63:32];
      end
      start[12] = ctr;
      start[13] = nonce_low_reg[31:0];
      start[14] = nonce_low_reg[63:32];
      start[15] = nonce_high_reg;
      x = start;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         // column round
         quarter_round(x[0], x[4], x[8], x[12]);
         quarter_round(x[1], x[5], x[9], x[13]);
         quarter_round(x[2], x[6], x[10], x[14]);
         quarter_round(x[3], x[7], x[11], x[15]);
         // diagonal round
         quarter_round(x[0], x[5], x[10], x[15]);
         quarter_round(x[1], x[6], x[11], x[12]);
         quarter_round(x[2], x[7], x[8], x[13]);
         quarter_round(x[3], x[4], x[9], x[14]);
      end
      for (int k = 0; k < 8; k++) begin
         ks[k] = {x[2 * k + 1] + start[2 * k + 1], x[2 * k] + start[2 * k]};
      end
      return ks;
   endfunction

   // register write as seen by the predictor
   function automatic void apply_write(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
         CSR_KEY_WORD0: key_reg[0] = data;
         CSR_KEY_WORD1: key_reg[1] = data;
         CSR_KEY_WORD2: key_reg[2] = data;
         CSR_KEY_WORD3: key_reg[3] = data;
         CSR_NONCE_LOW: nonce_low_reg = data;
         CSR_NONCE_HIGH: nonce_high_reg = data[31:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // request driver and response stall, both change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || req_taken) begin
            if (counter_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_block_counter <= counter_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      keystream_beat_type beat;
      keystream_beat_type want;
      block_type          ks;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            ks = chacha_keystream(req_block_counter);
            for (int k = 0; k < 8; k++) begin
               beat.word = ks[k];
               beat.index = 3'(k);
               beat.last = (3'(k) == LAST_WORD_INDEX);
               keystream_expected.push_back(beat);
            end
            blocks_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (keystream_expected.size() == 0) begin
               report_mismatch("word with no block outstanding", rsp_keystream_word, '0);
            end else begin
               want = keystream_expected.pop_front();
               if (rsp_keystream_word !== want.word) begin
                  report_mismatch("keystream_word", rsp_keystream_word, want.word);
               end
               if (rsp_word_index !== want.index) begin
                  report_mismatch("word_index", 64'(rsp_word_index), 64'(want.index));
               end
               if (rsp_last_word !== want.last) begin
                  report_mismatch("last_word", 64'(rsp_last_word), 64'(want.last));
               end
               words_checked++;
            end
         end
         // watchdog on cycles with no transfer on either channel
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic queue_counter(input word_type ctr);
      counter_queue.push_back(ctr);
      blocks_queued++;
   endtask

   // hold the sender until every queued block has been answered
   task automatic wait_drained();
      while (blocks_accepted != blocks_queued || keystream_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_write(idx, data);
   endtask

   // all six registers, then both spare indexes which must change nothing
   task automatic load_settings(input key_type k, input logic [63:0] nl,
                                input logic [63:0] nh, input logic [63:0] spare);
      write_reg(CSR_KEY_WORD0, k[0]);
      write_reg(CSR_KEY_WORD1, k[1]);
      write_reg(CSR_KEY_WORD2, k[2]);
      write_reg(CSR_KEY_WORD3, k[3]);
      write_reg(CSR_NONCE_LOW, nl);
      write_reg(CSR_NONCE_HIGH, nh);
      write_reg(CSR_SPARE_LO, spare);
      write_reg(CSR_SPARE_HI, ~spare);
      @(negedge clock);
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic word_type pick_counter();
      case ($urandom_range(15))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      int      send_mix[4];
      int      stall_mix[4];
      key_type k;
      send_mix = '{0, 74, 0, 29};
      stall_mix = '{0, 0, 74, 29};
      clock = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_block_counter = '0;
      rsp_stall = 1'b0;
      key_reg = '0;
      nonce_low_reg = '0;
      nonce_high_reg = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      blocks_queued = 0;
      blocks_accepted = 0;
      words_checked = 0;
      settings_loaded = 1;
      error_count = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // all-zero key and nonce straight out of reset, counter extremes
      queue_counter(32'h0000_0000);
      queue_counter(32'h0000_0001);
      queue_counter(32'hffff_ffff);
      queue_counter(32'h8000_0000);
      queue_counter(32'h7fff_ffff);
      wait_drained();

      // standard test key 00..1f with nonce 000000090000004a00000000,
      // junk in the upper nonce_high bits must be dropped
      k[0] = 64'h0706_0504_0302_0100;
      k[1] = 64'h0f0e_0d0c_0b0a_0908;
      k[2] = 64'h1716_1514_1312_1110;
      k[3] = 64'h1f1e_1d1c_1b1a_1918;
      load_settings(k, 64'h4a00_0000_0900_0000, 64'hdead_beef_0000_0000,
                    64'hffff_ffff_ffff_ffff);
      queue_counter(32'h0000_0001);
      queue_counter(32'h0000_0000);
      queue_counter(32'h0000_0002);
      queue_counter(32'hffff_ffff);
      wait_drained();

      // every register bit set
      load_settings('1, '1, '1, '0);
      queue_counter(32'h0000_0000);
      queue_counter(32'hffff_ffff);
      queue_counter(32'h5555_5555);
      queue_counter(32'haaaa_aaaa);
      wait_drained();

      // random settings under each handshake mix, with one drain mid-phase
      for (int m = 0; m < 4; m++) begin
         for (int i = 0; i < 4; i++) begin
            k[i] = rand64();
         end
         load_settings(k, rand64(), rand64(), rand64());
         send_idle_pct = send_mix[m];
         stall_pct = stall_mix[m];
         for (int i = 0; i < RANDOM_BLOCKS; i++) begin
            queue_counter(pick_counter());
            if (i == RANDOM_BLOCKS / 2) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      // let any stray words show up
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d keystream blocks, %0d words checked, %0d key/nonce settings",
               blocks_accepted, words_checked, settings_loaded);
      $display("handshake mixes: free flow, sender gaps, response stalls, both; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== chacha20_keystream_block.f =====
sv/chacha_pkg.sv
sv/chacha20_keystream_block.sv
sim/tb_top.sv
